[rtl/core/deq_pkg.sv]
//------------------------------------------------------------------------------
// deq_pkg
// shared types and sizes for the bounded double-ended queue engine
//------------------------------------------------------------------------------
`default_nettype none

package deq_pkg;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int FUNC_W     = 4;
  localparam int STAT_W     = 2;

  typedef enum logic [FUNC_W-1:0] {
    FN_PUSH_BACK  = 4'd0,
    FN_PUSH_FRONT = 4'd1,
    FN_POP_BACK   = 4'd2,
    FN_POP_FRONT  = 4'd3,
    FN_READ_AT    = 4'd4,
    FN_SEARCH     = 4'd5,
    FN_WALK_FWD   = 4'd6,
    FN_WALK_BACK  = 4'd7,
    FN_CLEAR      = 4'd8
  } func_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_ENDS,
    S_GRAB,
    S_SCAN,
    S_EMIT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic exec;
    logic ends;
    logic grab;
    logic step;
    logic walk_out;
  } dp_ctl_t;

  // datapath to controller
  typedef struct packed {
    logic is_walk;
    logic scan_go;
    logic scan_last;
    logic match;
  } dp_sts_t;

endpackage

`default_nettype wire

[rtl/core/deq_ctrl.sv]
//------------------------------------------------------------------------------
// deq_ctrl
// operation sequencer: accept, update, end fetch, scan and result strobe
//------------------------------------------------------------------------------
`default_nettype none

module deq_ctrl
  import deq_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    start,
  output logic         busy,
  output dp_ctl_t      ctl,
  input  dp_sts_t      sts,
  output logic         out_valid
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    out_valid = 1'b0;
    busy      = (state_r != S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          ctl.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        ctl.exec  = 1'b1;
        state_nxt = S_ENDS;
      end
      S_ENDS: begin
        ctl.ends  = 1'b1;
        state_nxt = S_GRAB;
      end
      S_GRAB: begin
        ctl.grab  = 1'b1;
        state_nxt = sts.scan_go ? S_SCAN : S_EMIT;
      end
      S_SCAN: begin
        if (sts.is_walk) begin
          out_valid    = 1'b1;
          ctl.walk_out = 1'b1;
          if (sts.scan_last) begin
            state_nxt = S_IDLE;
          end else begin
            ctl.step = 1'b1;
          end
        end else if (sts.match) begin
          ctl.step  = 1'b1;
          state_nxt = S_EMIT;
        end else if (sts.scan_last) begin
          state_nxt = S_EMIT;
        end else begin
          ctl.step = 1'b1;
        end
      end
      S_EMIT: begin
        out_valid = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[rtl/core/deq_datapath.sv]
//------------------------------------------------------------------------------
// deq_datapath
// ring store, front index, element count and result registers
//------------------------------------------------------------------------------
`default_nettype none

module deq_datapath
  import deq_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  dp_ctl_t                    ctl,
  output dp_sts_t                    sts,
  input  wire logic [FUNC_W-1:0]     in_func,
  input  wire logic [DATA_WIDTH-1:0] in_value,
  input  wire logic [CNT_W-1:0]      in_position,
  output logic [DATA_WIDTH-1:0]      out_data,
  output logic [CNT_W-1:0]           out_found_at,
  output logic [STAT_W-1:0]          out_status,
  output logic [CNT_W-1:0]           out_entries,
  output logic [DATA_WIDTH-1:0]      out_front_value,
  output logic [DATA_WIDTH-1:0]      out_back_value,
  output logic                       out_last
);

  localparam logic [IDX_W:0] DEPTH_X = (IDX_W + 1)'(DEPTH);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  logic [IDX_W-1:0]      front_idx_r;
  logic [IDX_W-1:0]      front_idx_nxt;
  logic [CNT_W-1:0]      count_r;
  logic [CNT_W-1:0]      count_nxt;

  func_t                 func_r;
  logic [DATA_WIDTH-1:0] value_r;
  logic [CNT_W-1:0]      pos_r;
  status_t               status_r;
  status_t               status_nxt;
  logic [DATA_WIDTH-1:0] data_r;
  logic [DATA_WIDTH-1:0] front_r;
  logic [DATA_WIDTH-1:0] back_r;
  logic [CNT_W-1:0]      found_r;
  logic [IDX_W-1:0]      k_r;
  logic [DATA_WIDTH-1:0] rd_a_r;
  logic [DATA_WIDTH-1:0] rd_b_r;

  logic                  wr_en;
  logic [IDX_W-1:0]      wr_addr;
  logic [IDX_W-1:0]      addr_a;
  logic [IDX_W-1:0]      addr_b;
  logic                  rd_en;
  logic                  empty;
  logic                  full;
  logic                  is_walk;
  logic                  is_search;
  logic [CNT_W-1:0]      k_ext;
  logic [CNT_W-1:0]      k_next;
  logic [CNT_W-1:0]      last_ofs;

  function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] base,
                                                input logic [IDX_W-1:0] ofs);
    logic [IDX_W:0] sum;
    sum = {1'b0, base} + {1'b0, ofs};
    if (sum >= DEPTH_X) begin
      sum = sum - DEPTH_X;
    end
    return sum[IDX_W-1:0];
  endfunction

  function automatic logic [IDX_W-1:0] scan_ofs(input logic           back,
                                                input logic [CNT_W-1:0] cnt,
                                                input logic [CNT_W-1:0] k);
    logic [CNT_W-1:0] ofs;
    ofs = back ? (cnt - CNT_W'(1) - k) : k;
    return ofs[IDX_W-1:0];
  endfunction

  assign empty     = (count_r == '0);
  assign full      = (count_r == FULL_CNT);
  assign is_walk   = (func_r == FN_WALK_FWD) || (func_r == FN_WALK_BACK);
  assign is_search = (func_r == FN_SEARCH);
  assign k_ext     = CNT_W'(k_r);
  assign k_next    = k_ext + CNT_W'(1);
  assign last_ofs  = count_r - CNT_W'(1);

  // operation update
  always_comb begin
    front_idx_nxt = front_idx_r;
    count_nxt     = count_r;
    status_nxt    = ST_OK;
    wr_en         = 1'b0;
    wr_addr       = wrap_add(front_idx_r, count_r[IDX_W-1:0]);
    unique case (func_r) inside
      FN_PUSH_BACK, FN_PUSH_FRONT: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          wr_en     = 1'b1;
          count_nxt = count_r + CNT_W'(1);
          if (func_r == FN_PUSH_FRONT) begin
            front_idx_nxt = (front_idx_r == '0) ? IDX_W'(DEPTH - 1)
                                                : front_idx_r - IDX_W'(1);
            wr_addr       = front_idx_nxt;
          end
        end
      end
      FN_POP_BACK, FN_POP_FRONT: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          count_nxt = count_r - CNT_W'(1);
          if (func_r == FN_POP_FRONT) begin
            front_idx_nxt = wrap_add(front_idx_r, IDX_W'(1));
          end
        end
      end
      FN_READ_AT: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else if (pos_r == '0 || pos_r > count_r) begin
          status_nxt = ST_RANGE;
        end
      end
      FN_SEARCH, FN_WALK_FWD, FN_WALK_BACK: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end
      end
      FN_CLEAR: begin
        count_nxt = '0;
      end
      default: begin
        status_nxt = ST_OK;
      end
    endcase
  end

  // read addresses
  always_comb begin
    addr_b = wrap_add(front_idx_r, last_ofs[IDX_W-1:0]);
    rd_en  = ctl.exec | ctl.ends | ctl.grab | ctl.step;
    if (ctl.exec) begin
      addr_a = wrap_add(front_idx_r, IDX_W'(pos_r - CNT_W'(1)));
    end else if (ctl.ends) begin
      addr_a = front_idx_r;
    end else if (ctl.grab) begin
      addr_a = wrap_add(front_idx_r,
                        scan_ofs(func_r == FN_WALK_BACK, count_r, '0));
    end else begin
      addr_a = wrap_add(front_idx_r,
                        scan_ofs(func_r == FN_WALK_BACK, count_r, k_next));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_idx_r <= '0;
      count_r     <= '0;
    end else if (ctl.exec) begin
      front_idx_r <= front_idx_nxt;
      count_r     <= count_nxt;
    end
  end

  // ring store
  always_ff @(posedge clk) begin
    if (ctl.exec && wr_en) begin
      mem[wr_addr] <= value_r;
    end
    if (rd_en) begin
      rd_a_r <= mem[addr_a];
      rd_b_r <= mem[addr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      func_r  <= func_t'(in_func);
      value_r <= in_value;
      pos_r   <= in_position;
      found_r <= '0;
    end
    if (ctl.exec) begin
      status_r <= status_nxt;
    end
    if (ctl.ends) begin
      data_r <= (func_r == FN_READ_AT && status_r == ST_OK) ? rd_a_r : '0;
    end
    if (ctl.grab) begin
      front_r <= empty ? '0 : rd_a_r;
      back_r  <= empty ? '0 : rd_b_r;
      k_r     <= '0;
    end
    if (ctl.step) begin
      k_r <= k_next[IDX_W-1:0];
      if (is_search && rd_a_r == value_r) begin
        found_r <= k_next;
      end
    end
  end

  assign sts.is_walk   = is_walk;
  assign sts.scan_go   = (is_walk || is_search) && !empty;
  assign sts.scan_last = (k_ext == last_ofs);
  assign sts.match     = (rd_a_r == value_r);

  assign out_data        = ctl.walk_out ? rd_a_r : data_r;
  assign out_found_at    = found_r;
  assign out_status      = ctl.walk_out ? ST_OK : status_r;
  assign out_entries     = count_r;
  assign out_front_value = front_r;
  assign out_back_value  = back_r;
  assign out_last        = ctl.walk_out ? sts.scan_last : 1'b1;

endmodule

`default_nettype wire

[rtl/core/double_ended_queue_engine.sv]
//------------------------------------------------------------------------------
// double_ended_queue_engine
// bounded deque in a ring store: push, pop, read, search, walk and clear
// sequence: accept, then the EXEC, ENDS and GRAB states, then the EMIT result
//   strobe; push, pop, read, clear and other codes take this path
// search scans from the front until the first match or the last element;
//   walks give one result beat per cycle during the scan, then return
// the ring store port, one read per element, sets the scan rate
// reset: synchronous active-low rst_n empties the queue; results cannot stall
//------------------------------------------------------------------------------
`default_nettype none

module double_ended_queue_engine
  import deq_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [FUNC_W-1:0]     in_func,
  input  wire logic [DATA_WIDTH-1:0] in_value,
  input  wire logic [CNT_W-1:0]      in_position,
  output logic                       out_valid,
  output logic [DATA_WIDTH-1:0]      out_data,
  output logic [CNT_W-1:0]           out_found_at,
  output logic [STAT_W-1:0]          out_status,
  output logic [CNT_W-1:0]           out_entries,
  output logic [DATA_WIDTH-1:0]      out_front_value,
  output logic [DATA_WIDTH-1:0]      out_back_value,
  output logic                       out_last
);

  dp_ctl_t ctl;
  dp_sts_t sts;

  deq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .ctl       (ctl),
    .sts       (sts),
    .out_valid (out_valid)
  );

  deq_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctl             (ctl),
    .sts             (sts),
    .in_func         (in_func),
    .in_value        (in_value),
    .in_position     (in_position),
    .out_data        (out_data),
    .out_found_at    (out_found_at),
    .out_status      (out_status),
    .out_entries     (out_entries),
    .out_front_value (out_front_value),
    .out_back_value  (out_back_value),
    .out_last        (out_last)
  );

endmodule

`default_nettype wire
